/* src/stsc_pkg.sv */
// Shared types, character constants and classification functions for the token scanner.
package stsc_pkg;

	// Width of the byte offset counters; offsets wrap at this width
	localparam int POS_W = 32;
	localparam int LEN_W = 32;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_UP_H = 8'h48;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [4:0] {
		TK_EOF, TK_UNKNOWN, TK_IDENT, TK_INTEGER, TK_STRING,
		TK_EQ_EQ, TK_EQ, TK_NOT_EQ, TK_NOT, TK_OR_OR, TK_AND_AND, TK_AND,
		TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_COMMA, TK_DOT, TK_SEMI,
		TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_COLON, TK_LBRACK,
		TK_RBRACK, TK_LE, TK_LT, TK_GE, TK_GT
	} token_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_HEX_IN_DECIMAL,
		ERR_UNTERMINATED
	} error_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUM,
		MODE_STR,
		MODE_CMT,
		MODE_OP
	} scan_mode_t;

	typedef struct packed {
		token_kind_t kind;
		logic [31:0] start;
		logic [LEN_W-1:0] length;
		error_code_t err;
		logic last;
	} result_t;

	// Results of one step, packed in order: r0 first, then r1
	typedef struct packed {
		logic [1:0] count;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic [31:0] pos_to_start(input logic [POS_W-1:0] p);
		logic [POS_W+31:0] wide;
		wide = {32'b0, p};
		return wide[31:0];
	endfunction

	function automatic logic is_head(input logic [7:0] c);
		return c == CH_USCORE || (c >= CH_UP_A && c <= CH_UP_Z) ||
			(c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_hexlet(input logic [7:0] c);
		return c >= CH_UP_A && c <= CH_UP_F;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT ||
			c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_op_head(input logic [7:0] c);
		return c == CH_EQ || c == CH_BANG || c == CH_AMP || c == CH_BAR ||
			c == CH_SLASH || c == CH_LT || c == CH_GT;
	endfunction

	// Kind of a waiting operator byte that found no partner
	function automatic token_kind_t single_kind(input logic [7:0] op);
		token_kind_t k;
		case (op)
			CH_EQ: k = TK_EQ;
			CH_BANG: k = TK_NOT;
			CH_AMP: k = TK_AND;
			CH_SLASH: k = TK_SLASH;
			CH_LT: k = TK_LT;
			CH_GT: k = TK_GT;
			default: k = TK_UNKNOWN;
		endcase
		return k;
	endfunction

	// Kind of a two-byte operator; TK_EOF when the pair forms none
	function automatic token_kind_t pair_kind(input logic [7:0] op, input logic [7:0] c);
		token_kind_t k;
		k = TK_EOF;
		if (c == CH_EQ) begin
			case (op)
				CH_EQ: k = TK_EQ_EQ;
				CH_BANG: k = TK_NOT_EQ;
				CH_LT: k = TK_LE;
				CH_GT: k = TK_GE;
				default: k = TK_EOF;
			endcase
		end else if (op == CH_AMP && c == CH_AMP) begin
			k = TK_AND_AND;
		end else if (op == CH_BAR && c == CH_BAR) begin
			k = TK_OR_OR;
		end
		return k;
	endfunction

	function automatic token_kind_t one_byte_kind(input logic [7:0] c);
		token_kind_t k;
		case (c)
			CH_PLUS: k = TK_PLUS;
			CH_MINUS: k = TK_MINUS;
			CH_STAR: k = TK_STAR;
			CH_COMMA: k = TK_COMMA;
			CH_DOT: k = TK_DOT;
			CH_SEMI: k = TK_SEMI;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			CH_COLON: k = TK_COLON;
			CH_LBRACK: k = TK_LBRACK;
			CH_RBRACK: k = TK_RBRACK;
			default: k = TK_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic result_t mk_result(
		input token_kind_t kind,
		input logic [POS_W-1:0] start,
		input logic [LEN_W-1:0] length,
		input error_code_t err
	);
		result_t r;
		r.kind = kind;
		r.start = pos_to_start(start);
		r.length = length;
		r.err = err;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

/* src/stsc_text_if.sv */
// Channel carrying source bytes into the scanner.
interface stsc_text_if;
	logic valid;
	logic ready;
	logic [7:0] text_byte;
	logic end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/stsc_token_if.sv */
// Channel carrying finished tokens out of the scanner.
interface stsc_token_if;
	logic valid;
	logic ready;
	logic [4:0] token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic [1:0] error_code;
	logic last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output error_code, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input error_code, input last_of_run, output ready);
endinterface

/* src/stsc_core.sv */
// Input register and per-byte scanner state update producing up to two results.
module stsc_core (
	input logic clk,
	input logic arst_n,
	stsc_text_if.sink text,
	input logic room,
	output stsc_pkg::push_t push
);
	import stsc_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eot_s1;
	logic advance;

	scan_mode_t mode_q, mode_d;
	logic [7:0] pend_op_q, pend_op_d;
	logic [POS_W-1:0] tok_begin_q, tok_begin_d;
	logic [POS_W-1:0] byte_pos_q, byte_pos_d;
	logic saw_hex_q, saw_hex_d;
	logic [LEN_W-1:0] tlen_q, tlen_d;

	logic [LEN_W-1:0] tlen_inc;
	logic taken;
	logic a_v, b_v;
	result_t a_r, b_r;
	token_kind_t pk;

	assign advance = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	// Hold the accepted byte until the queue has room for its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			eot_s1 <= text.end_of_text;
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_op_q <= '0;
			tok_begin_q <= '0;
			byte_pos_q <= '0;
			saw_hex_q <= 1'b0;
			tlen_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			pend_op_q <= pend_op_d;
			tok_begin_q <= tok_begin_d;
			byte_pos_q <= byte_pos_d;
			saw_hex_q <= saw_hex_d;
			tlen_q <= tlen_d;
		end
	end

	assign tlen_inc = (tlen_q == LEN_MAX) ? tlen_q : tlen_q + 1'b1;

	// Step: close or extend the pending token, then maybe open a new one
	always_comb begin
		mode_d = mode_q;
		pend_op_d = pend_op_q;
		tok_begin_d = tok_begin_q;
		byte_pos_d = byte_pos_q + 1'b1;
		saw_hex_d = saw_hex_q;
		tlen_d = tlen_q;
		taken = 1'b0;
		a_v = 1'b0;
		b_v = 1'b0;
		a_r = mk_result(TK_EOF, tok_begin_q, tlen_q, ERR_NONE);
		b_r = mk_result(TK_EOF, byte_pos_q, '0, ERR_NONE);
		pk = pair_kind(pend_op_q, byte_s1);

		if (eot_s1) begin
			// Flush the open token, then report end of text and start over
			case (mode_q)
				MODE_IDENT: begin
					a_v = 1'b1;
					a_r = mk_result(TK_IDENT, tok_begin_q, tlen_q, ERR_NONE);
				end
				MODE_NUM: begin
					a_v = 1'b1;
					a_r = mk_result(TK_INTEGER, tok_begin_q, tlen_q,
						saw_hex_q ? ERR_HEX_IN_DECIMAL : ERR_NONE);
				end
				MODE_STR: begin
					a_v = 1'b1;
					a_r = mk_result(TK_STRING, tok_begin_q, tlen_q, ERR_UNTERMINATED);
				end
				MODE_OP: begin
					a_v = 1'b1;
					a_r = mk_result(single_kind(pend_op_q), tok_begin_q, LEN_W'(1),
						ERR_NONE);
				end
				default: a_v = 1'b0;
			endcase
			b_v = 1'b1;
			mode_d = MODE_IDLE;
			pend_op_d = '0;
			tok_begin_d = '0;
			byte_pos_d = '0;
			saw_hex_d = 1'b0;
			tlen_d = '0;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_head(byte_s1) || is_dig(byte_s1)) begin
						tlen_d = tlen_inc;
						taken = 1'b1;
					end else begin
						a_v = 1'b1;
						a_r = mk_result(TK_IDENT, tok_begin_q, tlen_q, ERR_NONE);
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUM: begin
					if (is_dig(byte_s1) || is_hexlet(byte_s1)) begin
						tlen_d = tlen_inc;
						if (is_hexlet(byte_s1)) begin
							saw_hex_d = 1'b1;
						end
						taken = 1'b1;
					end else if (byte_s1 == CH_UP_H) begin
						tlen_d = tlen_inc;
						a_v = 1'b1;
						a_r = mk_result(TK_INTEGER, tok_begin_q, tlen_inc, ERR_NONE);
						mode_d = MODE_IDLE;
						taken = 1'b1;
					end else begin
						a_v = 1'b1;
						a_r = mk_result(TK_INTEGER, tok_begin_q, tlen_q,
							saw_hex_q ? ERR_HEX_IN_DECIMAL : ERR_NONE);
						mode_d = MODE_IDLE;
					end
				end
				MODE_STR: begin
					tlen_d = tlen_inc;
					taken = 1'b1;
					if (byte_s1 == CH_QUOTE) begin
						a_v = 1'b1;
						a_r = mk_result(TK_STRING, tok_begin_q, tlen_inc, ERR_NONE);
						mode_d = MODE_IDLE;
					end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						a_v = 1'b1;
						a_r = mk_result(TK_STRING, tok_begin_q, tlen_inc, ERR_UNTERMINATED);
						mode_d = MODE_IDLE;
					end
				end
				MODE_CMT: begin
					taken = 1'b1;
					if (byte_s1 == CH_LF) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_OP: begin
					if (pend_op_q == CH_SLASH && byte_s1 == CH_SLASH) begin
						mode_d = MODE_CMT;
						taken = 1'b1;
					end else if (pk != TK_EOF) begin
						a_v = 1'b1;
						a_r = mk_result(pk, tok_begin_q, LEN_W'(2), ERR_NONE);
						mode_d = MODE_IDLE;
						taken = 1'b1;
					end else begin
						a_v = 1'b1;
						a_r = mk_result(single_kind(pend_op_q), tok_begin_q, LEN_W'(1),
							ERR_NONE);
						mode_d = MODE_IDLE;
					end
					pend_op_d = '0;
				end
				default: mode_d = MODE_IDLE;
			endcase

			// Open a new token on a byte nobody consumed
			if (!taken && !is_space(byte_s1)) begin
				tok_begin_d = byte_pos_q;
				tlen_d = LEN_W'(1);
				if (is_head(byte_s1)) begin
					mode_d = MODE_IDENT;
				end else if (is_dig(byte_s1)) begin
					mode_d = MODE_NUM;
					saw_hex_d = 1'b0;
				end else if (byte_s1 == CH_QUOTE) begin
					mode_d = MODE_STR;
				end else if (is_op_head(byte_s1)) begin
					mode_d = MODE_OP;
					pend_op_d = byte_s1;
				end else begin
					b_v = 1'b1;
					b_r = mk_result(one_byte_kind(byte_s1), byte_pos_q, LEN_W'(1),
						ERR_NONE);
				end
			end
		end
	end

	// Pack results in order and mark the final one
	always_comb begin
		push.r0 = a_v ? a_r : b_r;
		push.r1 = b_r;
		push.r0.last = !(a_v && b_v);
		push.r1.last = 1'b1;
		if (!advance) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, a_v} + {1'b0, b_v};
		end
	end

endmodule

/* src/stsc_out_fifo.sv */
// Result queue taking up to two results per cycle and driving the token channel.
module stsc_out_fifo (
	input logic clk,
	input logic arst_n,
	input stsc_pkg::push_t push,
	output logic room,
	stsc_token_if.source tokens
);
	import stsc_pkg::*;

	result_t mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic pop;
	result_t head;

	assign pop = tokens.valid && tokens.ready;
	assign room = count_q <= FIFO_CW'(FIFO_DEPTH - 2);

	// Store incoming results in order
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

	assign head = mem[rd_ptr_q];
	assign tokens.valid = count_q != '0;
	assign tokens.token_kind = head.kind;
	assign tokens.token_start = head.start;
	assign tokens.token_length = head.length;
	assign tokens.error_code = head.err;
	assign tokens.last_of_run = head.last;

endmodule

/* src/source_token_scanner.sv */
// Top level of the streaming source token scanner.
//
//   channel  role   payload
//   text     sink   text_byte[7:0], end_of_text
//   tokens   source token_kind[4:0], token_start[31:0], token_length[31:0],
//                   error_code[1:0], last_of_run
//
// One byte is taken per cycle while the result queue has room; its results pass the
// input register, then the queue, before they are offered on tokens.
// A byte yields zero, one or two tokens; the token channel moves one per cycle,
// so with tokens ready the rate is one byte per cycle unless two-token bytes pile up.
// A stall on tokens lets the four-entry result queue reach three or four entries,
// then, with a byte waiting, holds text ready low until it drains to two.
// Reset returns the scanner to offset zero between tokens with an empty queue.
module source_token_scanner (
	input logic clk,
	input logic arst_n,
	stsc_text_if.sink text,
	stsc_token_if.source tokens
);
	import stsc_pkg::*;

	push_t push;
	logic room;

	stsc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.room(room),
		.push(push)
	);

	stsc_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.tokens(tokens)
	);

endmodule
